// File: rtl/lkv_pkg.sv
package lkv_pkg;

    // Field widths fixed by the transaction format.
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;

    // Configuration port geometry: one register, read as a 32-bit word, at byte address 0.
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int CAP_REG_W = 5;

    // Register index decoded from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    // Reset value of the capacity register.
    localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried on the kind field.
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // Outcome of one operation, passed from the lookup core to the datapath.
    typedef struct packed {
        logic hit;
        logic evicted;
        logic value_write;
        logic value_read;
    } op_status_t;

endpackage

// File: rtl/lkv_cfg.sv
module lkv_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkv_pkg::PADDR_W-1:0]       paddr,
    input  logic [lkv_pkg::PDATA_W-1:0]       pwdata,
    output logic [lkv_pkg::PDATA_W-1:0]       prdata,
    output logic [lkv_pkg::CAP_REG_W-1:0]     capacity
);

    logic [lkv_pkg::CAP_REG_W-1:0] capacity_reg;
    logic                          wr_en;

    // A write completes in the access phase; pready is always high.
    assign wr_en = psel && penable && pwrite && (paddr[2] == lkv_pkg::REG_CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lkv_pkg::CAP_RESET;
        end else if (wr_en) begin
            capacity_reg <= pwdata[lkv_pkg::CAP_REG_W-1:0];
        end
    end

    // Read back the register; unused addresses read as zero.
    always_comb begin
        prdata = '0;
        if (paddr[2] == lkv_pkg::REG_CAPACITY) begin
            prdata = lkv_pkg::PDATA_W'(capacity_reg);
        end
    end

    assign capacity = capacity_reg;

endmodule

// File: rtl/lkv_value_mem.sv
module lkv_value_mem #(
    parameter int CAPACITY = 16
) (
    input  logic                                          aclk,
    input  logic                                          wr_en,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] addr,
    input  logic [lkv_pkg::DATA_W-1:0]                    wr_data,
    input  logic                                          rd_en,
    input  logic                                          rd_hit,
    output logic [lkv_pkg::DATA_W-1:0]                    rd_data
);

    logic [lkv_pkg::DATA_W-1:0] mem [CAPACITY];
    logic [lkv_pkg::DATA_W-1:0] rd_data_reg;

    // Single write port; a put writes its slot.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    // Registered read; a miss or a put returns zero.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rd_hit ? mem[addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lkv_core.sv
module lkv_core #(
    parameter int CAPACITY = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          exec,
    input  logic                                          kind,
    input  logic [lkv_pkg::KEY_W-1:0]                     key,
    input  logic [lkv_pkg::CAP_REG_W-1:0]                 capacity,
    output lkv_pkg::op_status_t                           status,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] slot
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int AW = SW;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [lkv_pkg::KEY_W-1:0] key_reg [CAPACITY];
    logic [CAPACITY-1:0]       valid_reg;
    logic [AW-1:0]             age_reg [CAPACITY];
    logic [CW-1:0]             count_reg;

    logic [7:0]          cap_wide;
    logic [CW-1:0]       cap_eff;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] free_onehot;
    logic [CAPACITY-1:0] younger;
    logic                found;
    logic                full;
    logic                is_put;
    logic [SW-1:0]       hit_slot;
    logic [SW-1:0]       evict_slot;
    logic [SW-1:0]       fill_slot;
    logic [AW-1:0]       hit_age;
    logic [AW-1:0]       oldest_age;
    logic                do_hit;
    logic                do_evict;
    logic                do_fill;
    logic                do_promote;

    always_comb begin
        // Clamp the configured capacity into one to CAPACITY.
        cap_wide = 8'(capacity);
        if (cap_wide == 8'd0) begin
            cap_wide = 8'd1;
        end
        if (cap_wide > 8'(CAPACITY)) begin
            cap_wide = 8'(CAPACITY);
        end
        cap_eff = CW'(cap_wide);
        full    = (count_reg >= cap_eff);
        is_put  = (kind == lkv_pkg::KIND_PUT);

        // Ages of valid entries run from zero up to count minus one.
        oldest_age = AW'(count_reg - CW'(1));

        // Lowest free slot as a one-hot vector.
        free_onehot = ~valid_reg & (valid_reg + CAPACITY'(1));

        // Parallel compare; valid keys are unique, so the encoders just OR.
        hit_slot   = '0;
        hit_age    = '0;
        evict_slot = '0;
        fill_slot  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = valid_reg[i] && (key_reg[i] == key);
            if (match[i]) begin
                hit_slot = hit_slot | SW'(i);
                hit_age  = hit_age | age_reg[i];
            end
            if (valid_reg[i] && (age_reg[i] == oldest_age)) begin
                evict_slot = evict_slot | SW'(i);
            end
            if (free_onehot[i]) begin
                fill_slot = fill_slot | SW'(i);
            end
        end
        found = |match;

        do_hit     = exec && found;
        do_evict   = exec && is_put && !found && full;
        do_fill    = exec && is_put && !found && !full;
        do_promote = do_hit || do_evict || do_fill;

        if (found) begin
            slot = hit_slot;
        end else if (full) begin
            slot = evict_slot;
        end else begin
            slot = fill_slot;
        end

        // Entries younger than the promoted one age by one step.
        for (int i = 0; i < CAPACITY; i++) begin
            if (found) begin
                younger[i] = (age_reg[i] < hit_age);
            end else if (full) begin
                younger[i] = (age_reg[i] < oldest_age);
            end else begin
                younger[i] = 1'b1;
            end
        end

        status.hit         = found;
        status.evicted     = is_put && !found && full;
        status.value_write = is_put;
        status.value_read  = !is_put && found;
    end

    // Replacement state: valid bits, ages and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            if (do_promote) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (SW'(i) == slot) begin
                        age_reg[i] <= '0;
                    end else if (valid_reg[i] && younger[i]) begin
                        age_reg[i] <= age_reg[i] + AW'(1);
                    end
                end
            end
            if (do_fill) begin
                valid_reg[slot] <= 1'b1;
                count_reg       <= count_reg + CW'(1);
            end
        end
    end

    // Key store; a new key lands in the filled or evicted slot.
    always_ff @(posedge aclk) begin
        if (do_evict || do_fill) begin
            key_reg[slot] <= key;
        end
    end

endmodule

// File: rtl/lru_key_value_cache_unit.sv
// Fully associative key-value cache with least-recently-used replacement.
// The s_ channel carries one operation per transaction: s_kind selects a get
// or a put, s_lookup_key is the key and s_write_value the value of a put.
// The m_ channel returns exactly one result per operation, in order: m_hit
// tells whether the key was present, m_read_value is the stored value on a
// get hit (zero otherwise) and m_evicted flags a put that displaced the
// least recent entry.
// An accepted operation is held in an input register while all entries
// are compared in parallel and the ages, keys and value memory are
// updated; its result is then registered. One operation is accepted
// every cycle while results are taken; the compare-and-update sets it.
// Reset empties the cache and sets the capacity register to 16. The APB
// port holds capacity_in_use at address 0; the user must write it only
// while idle; the block itself does not enforce this. When the receiver
// stalls, the result is held and one more operation waits in the input
// register; then s_ready drops until the result is taken.
module lru_key_value_cache_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkv_pkg::PADDR_W-1:0]       paddr,
    input  logic [lkv_pkg::PDATA_W-1:0]       pwdata,
    output logic [lkv_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic signed [lkv_pkg::KEY_W-1:0]  s_lookup_key,
    input  logic signed [lkv_pkg::DATA_W-1:0] s_write_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic signed [lkv_pkg::DATA_W-1:0] m_read_value,
    output logic                              m_evicted
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [lkv_pkg::CAP_REG_W-1:0] capacity;
    lkv_pkg::op_status_t           status;
    logic [SW-1:0]                 slot;
    logic [lkv_pkg::DATA_W-1:0]    rd_data;

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic                          kind_reg;
    logic [lkv_pkg::KEY_W-1:0]     key_reg;
    logic [lkv_pkg::DATA_W-1:0]    wval_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          hit_reg;
    logic                          evicted_reg;
    logic                          exec;
    logic                          in_take;

    assign pready = 1'b1;

    lkv_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .capacity (capacity)
    );

    // The held operation executes when the result register is free.
    assign exec    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || exec;
    assign in_take = s_valid && s_ready;

    lkv_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .exec     (exec),
        .kind     (kind_reg),
        .key      (key_reg),
        .capacity (capacity),
        .status   (status),
        .slot     (slot)
    );

    lkv_value_mem #(
        .CAPACITY (CAPACITY)
    ) u_value_mem (
        .aclk    (aclk),
        .wr_en   (exec && status.value_write),
        .addr    (slot),
        .wr_data (wval_reg),
        .rd_en   (exec),
        .rd_hit  (status.value_read),
        .rd_data (rd_data)
    );

    // Handshake state for the input and result registers.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (exec) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            kind_reg <= s_kind;
            key_reg  <= s_lookup_key;
            wval_reg <= s_write_value;
        end
    end

    // Result register flags; the read value is registered in the memory.
    always_ff @(posedge aclk) begin
        if (exec) begin
            hit_reg     <= status.hit;
            evicted_reg <= status.evicted;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hit        = hit_reg;
    assign m_evicted    = evicted_reg;
    assign m_read_value = rd_data;

endmodule

// File: verif/lru_key_value_cache_unit_tb.sv
module lru_key_value_cache_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W        = lkv_pkg::KEY_W;
    localparam int DATA_W       = lkv_pkg::DATA_W;
    localparam int PADDR_W      = lkv_pkg::PADDR_W;
    localparam int PDATA_W      = lkv_pkg::PDATA_W;
    localparam int CAP_REG_W    = lkv_pkg::CAP_REG_W;
    localparam int SLOTS        = 16;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 10;
    localparam int WAIT_MAX     = 16;
    localparam int PHASE_OPS    = 150;
    localparam int POOL_SIZE    = 32;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [PADDR_W-1:0] CAPACITY_ADDR =
        PADDR_W'(4 * int'(lkv_pkg::REG_CAPACITY));

    // One operation on the input channel and one result on the output channel.
    typedef struct {
        logic                     kind;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] value;
    } cache_op_t;

    typedef struct {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
    } cache_result_t;

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [PADDR_W-1:0]       paddr   = '0;
    logic [PDATA_W-1:0]       pwdata  = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_kind  = lkv_pkg::KIND_GET;
    logic signed [KEY_W-1:0]  s_lookup_key  = '0;
    logic signed [DATA_W-1:0] s_write_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_hit;
    logic signed [DATA_W-1:0] m_read_value;
    logic                     m_evicted;

    // Handshake flags captured at the rising edge for the falling-edge drivers.
    logic s_took = 1'b0;
    logic m_took = 1'b0;

    cache_op_t     pending_ops[$];
    cache_result_t expected_results[$];
    int unsigned   error_count = 0;
    bit            tx_steady   = 1'b0;
    bit            rx_steady   = 1'b0;
    int unsigned   send_gap    = 0;
    int unsigned   stall_left  = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // Shadow copy of the cache contents and the capacity register.
    logic [KEY_W-1:0]   slot_key   [SLOTS];
    logic [DATA_W-1:0]  slot_value [SLOTS];
    bit                 slot_valid [SLOTS];
    int unsigned        slot_age   [SLOTS];
    int unsigned        fill_count   = 0;
    logic [CAP_REG_W-1:0] capacity_reg = lkv_pkg::CAP_RESET;

    lru_key_value_cache_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_lookup_key  (s_lookup_key),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_read_value  (m_read_value),
        .m_evicted     (m_evicted)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Make slot s the most recent; valid entries younger than limit age by one.
    function automatic void make_most_recent(int s, int unsigned limit);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && i != s && slot_age[i] < limit) begin
                slot_age[i]++;
            end
        end
        slot_age[s] = 0;
    endfunction

    // Apply one operation to the shadow cache and return the result it gives.
    function automatic cache_result_t lru_access(cache_op_t op);
        cache_result_t res;
        int unsigned   room;
        int unsigned   oldest;
        int            slot;
        bit            found;
        bit            any;
        res   = '{hit: 1'b0, read_value: '0, evicted: 1'b0};
        room  = capacity_reg;
        found = 1'b0;
        any   = 1'b0;
        slot  = 0;
        oldest = 0;
        // A capacity of zero acts as one, and one above the slot count as the slot count.
        if (room < 1) begin
            room = 1;
        end
        if (room > SLOTS) begin
            room = SLOTS;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_key[i] == op.key) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            if (op.kind == lkv_pkg::KIND_GET) begin
                res.read_value = slot_value[slot];
            end else begin
                slot_value[slot] = op.value;
            end
            make_most_recent(slot, slot_age[slot]);
        end else if (op.kind == lkv_pkg::KIND_PUT) begin
            if (fill_count >= room) begin
                // Replace the least recent entry; occupancy never shrinks.
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_valid[i] && (!any || slot_age[i] > oldest)) begin
                        oldest = slot_age[i];
                        slot   = i;
                        any    = 1'b1;
                    end
                end
                res.evicted      = 1'b1;
                slot_key[slot]   = op.key;
                slot_value[slot] = op.value;
                make_most_recent(slot, oldest);
            end else begin
                // A new key takes the lowest-numbered free slot.
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!slot_valid[i]) begin
                        slot = i;
                    end
                end
                slot_valid[slot] = 1'b1;
                slot_key[slot]   = op.key;
                slot_value[slot] = op.value;
                fill_count++;
                make_most_recent(slot, SLOTS);
            end
        end
        return res;
    endfunction

    function automatic int unsigned draw_wait(bit steady);
        return steady ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("%0t ERROR %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Monitor: predict on every accepted operation, check every accepted result.
    always @(posedge aclk) begin
        cache_result_t want;
        s_took <= s_valid && s_ready;
        m_took <= m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(lru_access('{kind: s_kind, key: s_lookup_key,
                                                    value: s_write_value}));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transaction with none pending", m_read_value, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_hit !== want.hit) begin
                    report_mismatch("hit", DATA_W'(m_hit), DATA_W'(want.hit));
                end
                if (m_read_value !== want.read_value) begin
                    report_mismatch("read_value", m_read_value, want.read_value);
                end
                if (m_evicted !== want.evicted) begin
                    report_mismatch("evicted", DATA_W'(m_evicted), DATA_W'(want.evicted));
                end
            end
        end
    end

    // Driver: present queued operations, holding each until it is accepted.
    always @(negedge aclk) begin
        cache_op_t op;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (pending_ops.size() > 0) begin
                op = pending_ops.pop_front();
                s_kind        <= op.kind;
                s_lookup_key  <= op.key;
                s_write_value <= op.value;
                s_valid       <= 1'b1;
                send_gap = draw_wait(tx_steady);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: after each result transaction, hold m_ready low for a random wait from draw_wait.
    always @(negedge aclk) begin
        if (m_took) begin
            stall_left = draw_wait(rx_steady);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Write the capacity register through the APB port; only the low bits count.
    task automatic write_capacity(logic [PDATA_W-1:0] word);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= word;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        capacity_reg = word[CAP_REG_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_op(logic kind, logic [KEY_W-1:0] key, logic [DATA_W-1:0] value);
        pending_ops.push_back('{kind: kind, key: key, value: value});
    endtask

    // Mostly keys from a small pool so that hits and evictions are frequent.
    task automatic queue_random_ops(int count, int span);
        logic [KEY_W-1:0] key;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 85) begin
                key = key_pool[$urandom_range(0, span - 1)];
            end else begin
                key = $urandom;
            end
            queue_op($urandom_range(0, 1) ? lkv_pkg::KIND_PUT : lkv_pkg::KIND_GET,
                     key, $urandom);
        end
    endtask

    // Sender holds off until every queued operation has returned its result.
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_ops.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int               phase_caps[$];
        logic [PDATA_W-1:0] word;
        phase_caps = '{2, 0, 1, 5, 31, 16, 3, 1};
        repeat (6) phase_caps.push_back($urandom_range(0, 31));

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'hffff_ffff;
        key_pool[3] = 32'h0000_0000;
        for (int i = 4; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (phase_caps[p]) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            word = $urandom;
            word[CAP_REG_W-1:0] = CAP_REG_W'(phase_caps[p]);
            write_capacity(word);
            for (int i = 0; i < 4; i++) begin
                key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
            end

            if (p == 0) begin
                // Two entries: miss on empty, fills, recency order, eviction, updates.
                queue_op(lkv_pkg::KIND_GET, 32'h8000_0000, 32'h0000_0000);
                queue_op(lkv_pkg::KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
                queue_op(lkv_pkg::KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
                queue_op(lkv_pkg::KIND_GET, 32'h8000_0000, 32'h0000_0000);
                queue_op(lkv_pkg::KIND_PUT, 32'hffff_ffff, 32'h0000_0000);
                queue_op(lkv_pkg::KIND_GET, 32'h7fff_ffff, 32'h0000_0000);
                queue_op(lkv_pkg::KIND_GET, 32'hffff_ffff, 32'hffff_ffff);
                queue_op(lkv_pkg::KIND_PUT, 32'h8000_0000, 32'hffff_ffff);
                queue_op(lkv_pkg::KIND_GET, 32'h8000_0000, 32'h7fff_ffff);
                queue_op(lkv_pkg::KIND_PUT, 32'h0000_0000, 32'h5555_5555);
                queue_op(lkv_pkg::KIND_GET, 32'h0000_0000, 32'hffff_ffff);
                queue_op(lkv_pkg::KIND_PUT, 32'h0000_0000, 32'haaaa_aaaa);
            end else if (p == 1) begin
                // Zero capacity acts as one and sits below the current occupancy.
                queue_op(lkv_pkg::KIND_PUT, 32'h1234_5678, 32'hdead_beef);
                queue_op(lkv_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000);
                queue_op(lkv_pkg::KIND_GET, 32'h1234_5678, 32'h0000_0000);
            end
            queue_random_ops(PHASE_OPS, $urandom_range(2, POOL_SIZE));
            wait_idle();
        end

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule
